// ===== design/dlac_pkg.sv =====
package dlac_pkg;

    localparam int TAG_BITS   = 64;
    localparam int TIMER_BITS = 20;
    localparam int CMP_BITS   = 32;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    typedef enum logic [1:0] {
        MODE_OPENING = 2'd0,
        MODE_OPEN    = 2'd1,
        MODE_CLOSING = 2'd2,
        MODE_CLOSED  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_ACCESS_CODE  = 3'd0,
        CFG_ENTRY_TMO    = 3'd1,
        CFG_OPEN_TMO     = 3'd2,
        CFG_BLINK_IVL    = 3'd3,
        CFG_WRONG_BLINKS = 3'd4
    } t_cfg_index;

    localparam logic [15:0] RST_ACCESS_CODE  = 16'd4660;
    localparam logic [19:0] RST_ENTRY_TMO    = 20'd10000;
    localparam logic [19:0] RST_OPEN_TMO     = 20'd5000;
    localparam logic [19:0] RST_BLINK_IVL    = 20'd500;
    localparam logic [7:0]  RST_WRONG_BLINKS = 8'd6;

    typedef struct packed {
        logic        ms_tick;
        logic        key_valid;
        logic [3:0]  key_value;
        logic        tag_valid;
        logic [63:0] tag_id;
        logic        save_request;
        logic        lock_button;
        logic        magnet_closed;
    } t_in_word;

    typedef struct packed {
        logic [1:0] door_mode;
        logic       locked_led;
        logic       open_led;
        logic       wrong_event;
        logic       access_event;
        logic       saved_event;
        logic       left_open_change;
        logic       left_open;
    } t_out_word;

    typedef struct packed {
        logic [15:0] access_code;
        logic [19:0] code_entry_timeout_ms;
        logic [19:0] door_open_timeout_ms;
        logic [19:0] blink_interval_ms;
        logic [7:0]  wrong_blinks;
    } t_cfg;

    typedef struct packed {
        t_mode                 mode;
        logic [1:0]            keys_entered;
        logic [15:0]           entered_code;
        logic [TIMER_BITS-1:0] entry_timer;
        logic                  entry_running;
        logic [TIMER_BITS-1:0] open_timer;
        logic                  open_running;
        logic [TIMER_BITS-1:0] blink_timer;
        logic                  blink_running;
        logic [7:0]            blinks_left;
        logic                  blink_forever;
        logic                  locked_level;
        logic                  open_level;
        logic                  door_left_open;
        logic [TAG_BITS-1:0]   allowed_tag;
        logic                  allowed_present;
    } t_state;

    localparam t_cfg RST_CFG = '{
        access_code:           RST_ACCESS_CODE,
        code_entry_timeout_ms: RST_ENTRY_TMO,
        door_open_timeout_ms:  RST_OPEN_TMO,
        blink_interval_ms:     RST_BLINK_IVL,
        wrong_blinks:          RST_WRONG_BLINKS
    };

    localparam t_state RST_STATE = '{mode: MODE_CLOSED, default: '0};

endpackage

// ===== design/dlac_cfg.sv =====
module dlac_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [19:0]       i_cfg_data,
    output dlac_pkg::t_cfg    o_cfg
);

    dlac_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= dlac_pkg::RST_CFG;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dlac_pkg::CFG_ACCESS_CODE:  r_cfg.access_code <= i_cfg_data[15:0];
                dlac_pkg::CFG_ENTRY_TMO:    r_cfg.code_entry_timeout_ms <= i_cfg_data;
                dlac_pkg::CFG_OPEN_TMO:     r_cfg.door_open_timeout_ms <= i_cfg_data;
                dlac_pkg::CFG_BLINK_IVL:    r_cfg.blink_interval_ms <= i_cfg_data;
                dlac_pkg::CFG_WRONG_BLINKS: r_cfg.wrong_blinks <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== design/dlac_core.sv =====
module dlac_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  dlac_pkg::t_in_word  i_word,
    input  dlac_pkg::t_cfg      i_cfg,
    output dlac_pkg::t_out_word o_word
);

    dlac_pkg::t_state r_state;
    dlac_pkg::t_state n_state;

    function automatic logic [dlac_pkg::TIMER_BITS-1:0] tick_timer(
        input logic [dlac_pkg::TIMER_BITS-1:0] t,
        input logic                            running,
        input logic                            tick
    );
        if (running && tick && (t != dlac_pkg::TIMER_MAX)) begin
            return t + 1'b1;
        end
        return t;
    endfunction

    function automatic dlac_pkg::t_state blink_step(
        input dlac_pkg::t_state s,
        input logic [19:0]      interval
    );
        dlac_pkg::t_state r;
        r = s;
        if (r.blink_forever || (r.blinks_left != 8'd0)) begin
            if (dlac_pkg::CMP_BITS'(r.blink_timer) >= dlac_pkg::CMP_BITS'(interval)) begin
                r.locked_level = !r.locked_level;
                r.blink_timer  = '0;
                if (!r.blink_forever && (r.blinks_left != 8'd0)) begin
                    r.blinks_left = r.blinks_left - 8'd1;
                end
            end
        end
        if (!r.blink_forever && (r.blinks_left == 8'd0)) begin
            r.blink_timer   = '0;
            r.blink_running = 1'b0;
        end
        return r;
    endfunction

    always_comb begin
        dlac_pkg::t_state          s;
        logic                      wrong;
        logic                      ev_wrong;
        logic                      ev_access;
        logic                      ev_saved;
        logic                      ev_change;
        logic [1:0]                k;
        logic [dlac_pkg::TAG_BITS-1:0] tag;

        s         = r_state;
        wrong     = 1'b0;
        ev_wrong  = 1'b0;
        ev_access = 1'b0;
        ev_saved  = 1'b0;
        ev_change = 1'b0;
        k         = r_state.keys_entered;
        tag       = i_word.tag_id[dlac_pkg::TAG_BITS-1:0];

        s.entry_timer = tick_timer(s.entry_timer, s.entry_running, i_word.ms_tick);
        s.open_timer  = tick_timer(s.open_timer, s.open_running, i_word.ms_tick);
        s.blink_timer = tick_timer(s.blink_timer, s.blink_running, i_word.ms_tick);

        case (s.mode)
            dlac_pkg::MODE_CLOSED: begin
                if (i_word.tag_valid) begin
                    if (i_word.save_request) begin
                        s.allowed_tag     = tag;
                        s.allowed_present = 1'b1;
                        ev_saved          = 1'b1;
                    end
                    if (s.allowed_present && (tag == s.allowed_tag)) begin
                        s.mode = dlac_pkg::MODE_OPENING;
                    end else begin
                        wrong = 1'b1;
                    end
                end
                if (i_word.key_valid) begin
                    if (k == 2'd0) begin
                        s.entry_running = 1'b1;
                    end
                    s.entered_code[{~k, 2'b00} +: 4] = i_word.key_value;
                    if (k == 2'd3) begin
                        s.entry_running = 1'b0;
                        s.entry_timer   = '0;
                        s.keys_entered  = 2'd0;
                        if (s.entered_code != i_cfg.access_code) begin
                            wrong = 1'b1;
                        end
                        if (!wrong) begin
                            s.mode = dlac_pkg::MODE_OPENING;
                        end
                    end else begin
                        s.keys_entered = k + 2'd1;
                    end
                end
                if ((s.mode != dlac_pkg::MODE_OPENING) &&
                    (dlac_pkg::CMP_BITS'(s.entry_timer) >
                     dlac_pkg::CMP_BITS'(i_cfg.code_entry_timeout_ms))) begin
                    s.keys_entered  = 2'd0;
                    s.entry_running = 1'b0;
                    s.entry_timer   = '0;
                    wrong           = 1'b1;
                end
                if (wrong) begin
                    s.blinks_left   = i_cfg.wrong_blinks;
                    s.blink_forever = 1'b0;
                    s.blink_running = 1'b1;
                    ev_wrong        = 1'b1;
                end
                if (s.blink_forever || (s.blinks_left != 8'd0)) begin
                    s = blink_step(s, i_cfg.blink_interval_ms);
                end else begin
                    s.locked_level = 1'b1;
                    s.open_level   = 1'b0;
                end
            end
            dlac_pkg::MODE_OPENING: begin
                ev_access      = 1'b1;
                s.open_running = 1'b1;
                s.mode = i_word.lock_button ? dlac_pkg::MODE_CLOSING : dlac_pkg::MODE_OPEN;
            end
            dlac_pkg::MODE_OPEN: begin
                s.locked_level = 1'b0;
                s.open_level   = 1'b1;
                if (i_word.lock_button ||
                    (dlac_pkg::CMP_BITS'(s.open_timer) >=
                     dlac_pkg::CMP_BITS'(i_cfg.door_open_timeout_ms))) begin
                    s.mode = dlac_pkg::MODE_CLOSING;
                end
            end
            default: begin
                if (!i_word.magnet_closed) begin
                    s.open_level = 1'b1;
                    if (!s.door_left_open) begin
                        s.blink_forever  = 1'b1;
                        s.blinks_left    = 8'd0;
                        s.blink_running  = 1'b1;
                        s.door_left_open = 1'b1;
                        s.open_running   = 1'b1;
                        s.open_timer     = '0;
                        ev_change        = 1'b1;
                    end
                    s = blink_step(s, i_cfg.blink_interval_ms);
                end else begin
                    s.blinks_left   = 8'd0;
                    s.blink_forever = 1'b0;
                    if (s.door_left_open) begin
                        s.door_left_open = 1'b0;
                        ev_change        = 1'b1;
                    end
                    s.open_running = 1'b0;
                    s.open_timer   = '0;
                    s.mode         = dlac_pkg::MODE_CLOSED;
                end
            end
        endcase

        n_state                 = s;
        o_word.door_mode        = s.mode;
        o_word.locked_led       = s.locked_level;
        o_word.open_led         = s.open_level;
        o_word.wrong_event      = ev_wrong;
        o_word.access_event     = ev_access;
        o_word.saved_event      = ev_saved;
        o_word.left_open_change = ev_change;
        o_word.left_open        = s.door_left_open;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlac_pkg::RST_STATE;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/door_lock_access_controller_top.sv =====
// Door lock controller that takes one poll word per clock when the output side does not
// stall and returns exactly one result word for it, in order, through the input register
// and then the output register. The whole controller state is updated from the registered
// poll word, so a new word can enter in every cycle; an output register lets the next
// poll word enter while a finished result is still waiting. Configuration writes are
// always ready and take effect at once; indexes above four are ignored.
module door_lock_access_controller_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  dlac_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output dlac_pkg::t_out_word o_out_word,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [19:0]         i_cfg_data
);

    logic                r_in_valid;
    dlac_pkg::t_in_word  r_in;
    logic                r_out_valid;
    dlac_pkg::t_out_word r_out;
    dlac_pkg::t_out_word core_word;
    dlac_pkg::t_cfg      cfg;
    logic                advance;
    logic                in_accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    dlac_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dlac_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_word  (r_in),
        .i_cfg   (cfg),
        .o_word  (core_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_word;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed word did not reach the output register");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.left_open) |-> (r_out.door_mode == dlac_pkg::MODE_CLOSING))
        else $error("left-open flag outside the closing mode");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.access_event) |->
        ((r_out.door_mode == dlac_pkg::MODE_OPEN) ||
         (r_out.door_mode == dlac_pkg::MODE_CLOSING)))
        else $error("access reported without leaving the opening mode");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("held poll word lost or changed");

endmodule

// ===== test/door_lock_access_controller_top_test.sv =====
module door_lock_access_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD     = 6;
    localparam int CLK_PERIOD      = 2 * HALF_PERIOD;
    localparam int RESET_CYCLES    = 10;
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_POLLS     = 60;
    localparam int LONG_HOLD       = 80;
    localparam int TAIL_CYCLES     = 10;
    localparam int WATCHDOG_CYCLES = 200000;

    typedef struct {
        dlac_pkg::t_in_word  poll;
        bit                  typed;
        dlac_pkg::t_out_word want;
    } t_directed_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    dlac_pkg::t_in_word  i_in_word   = '0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [2:0]          i_cfg_index = dlac_pkg::CFG_ACCESS_CODE;
    logic [19:0]         i_cfg_data  = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_cfg_ready;
    dlac_pkg::t_out_word o_out_word;

    // Register copies and controller state as the checker sees them.
    logic [15:0]                     cfg_code;
    logic [19:0]                     cfg_entry_limit;
    logic [19:0]                     cfg_open_limit;
    logic [19:0]                     cfg_blink_period;
    logic [7:0]                      cfg_blink_count;
    dlac_pkg::t_mode                 door;
    logic [1:0]                      key_count;
    logic [15:0]                     code_buf;
    logic [dlac_pkg::TIMER_BITS-1:0] entry_ms;
    logic [dlac_pkg::TIMER_BITS-1:0] open_ms;
    logic [dlac_pkg::TIMER_BITS-1:0] blink_ms;
    logic                            entry_on;
    logic                            open_on;
    logic                            blink_on;
    logic [7:0]                      toggles_left;
    logic                            blink_endless;
    logic                            locked_lamp;
    logic                            open_lamp;
    logic                            left_open_flag;
    logic [dlac_pkg::TAG_BITS-1:0]   saved_tag;
    logic                            tag_saved;

    dlac_pkg::t_out_word expected_words[$];
    logic [63:0] known_tags[4];
    int          tick_pct = 50;
    bit          in_rush = 1'b0;
    bit          out_rush = 1'b0;
    int          hold_asked = 0;
    int          hold_done = 0;
    int          stall_left = 0;
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          polls_sent = 0;
    int          openings = 0;
    int          wrong_reports = 0;
    int          left_open_changes = 0;
    int          tags_stored = 0;

    door_lock_access_controller_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_word (o_out_word),
        .i_out_stall(i_out_stall),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void reset_lock_model();
        cfg_code         = dlac_pkg::RST_ACCESS_CODE;
        cfg_entry_limit  = dlac_pkg::RST_ENTRY_TMO;
        cfg_open_limit   = dlac_pkg::RST_OPEN_TMO;
        cfg_blink_period = dlac_pkg::RST_BLINK_IVL;
        cfg_blink_count  = dlac_pkg::RST_WRONG_BLINKS;
        door             = dlac_pkg::MODE_CLOSED;
        key_count        = '0;
        code_buf         = '0;
        entry_ms         = '0;
        open_ms          = '0;
        blink_ms         = '0;
        entry_on         = 1'b0;
        open_on          = 1'b0;
        blink_on         = 1'b0;
        toggles_left     = '0;
        blink_endless    = 1'b0;
        locked_lamp      = 1'b0;
        open_lamp        = 1'b0;
        left_open_flag   = 1'b0;
        saved_tag        = '0;
        tag_saved        = 1'b0;
    endfunction

    function automatic logic [dlac_pkg::TIMER_BITS-1:0] advance_ms(
        logic [dlac_pkg::TIMER_BITS-1:0] t, logic running, logic tick);
        return (running && tick && t != dlac_pkg::TIMER_MAX) ? t + 1'b1 : t;
    endfunction

    function automatic void step_blinker();
        if (blink_endless || toggles_left != 0) begin
            if (blink_ms >= cfg_blink_period) begin
                locked_lamp = ~locked_lamp;
                blink_ms = '0;
                if (!blink_endless && toggles_left != 0) begin
                    toggles_left = toggles_left - 1'b1;
                end
            end
        end
        if (!blink_endless && toggles_left == 0) begin
            blink_ms = '0;
            blink_on = 1'b0;
        end
    endfunction

    function automatic dlac_pkg::t_out_word poll_lock(dlac_pkg::t_in_word w);
        dlac_pkg::t_out_word r;
        logic                wrong;
        int                  shift;
        r = '0;
        wrong = 1'b0;
        entry_ms = advance_ms(entry_ms, entry_on, w.ms_tick);
        open_ms  = advance_ms(open_ms, open_on, w.ms_tick);
        blink_ms = advance_ms(blink_ms, blink_on, w.ms_tick);
        case (door)
            dlac_pkg::MODE_CLOSED: begin
                if (w.tag_valid) begin
                    if (w.save_request) begin
                        saved_tag = w.tag_id;
                        tag_saved = 1'b1;
                        r.saved_event = 1'b1;
                    end
                    if (tag_saved && w.tag_id == saved_tag) begin
                        door = dlac_pkg::MODE_OPENING;
                    end else begin
                        wrong = 1'b1;
                    end
                end
                if (w.key_valid) begin
                    shift = (3 - key_count) * 4;
                    if (key_count == 0) begin
                        entry_on = 1'b1;
                    end
                    code_buf[shift +: 4] = w.key_value;
                    if (key_count == 3) begin
                        entry_on = 1'b0;
                        entry_ms = '0;
                        key_count = '0;
                        if (code_buf != cfg_code) begin
                            wrong = 1'b1;
                        end
                        if (!wrong) begin
                            door = dlac_pkg::MODE_OPENING;
                        end
                    end else begin
                        key_count = key_count + 1'b1;
                    end
                end
                if (door != dlac_pkg::MODE_OPENING && entry_ms > cfg_entry_limit) begin
                    key_count = '0;
                    entry_on = 1'b0;
                    entry_ms = '0;
                    wrong = 1'b1;
                end
                if (wrong) begin
                    toggles_left = cfg_blink_count;
                    blink_endless = 1'b0;
                    blink_on = 1'b1;
                    r.wrong_event = 1'b1;
                end
                if (blink_endless || toggles_left != 0) begin
                    step_blinker();
                end else begin
                    locked_lamp = 1'b1;
                    open_lamp = 1'b0;
                end
            end
            dlac_pkg::MODE_OPENING: begin
                r.access_event = 1'b1;
                open_on = 1'b1;
                door = w.lock_button ? dlac_pkg::MODE_CLOSING : dlac_pkg::MODE_OPEN;
            end
            dlac_pkg::MODE_OPEN: begin
                locked_lamp = 1'b0;
                open_lamp = 1'b1;
                if (w.lock_button || open_ms >= cfg_open_limit) begin
                    door = dlac_pkg::MODE_CLOSING;
                end
            end
            default: begin
                if (!w.magnet_closed) begin
                    open_lamp = 1'b1;
                    if (!left_open_flag) begin
                        blink_endless = 1'b1;
                        toggles_left = '0;
                        blink_on = 1'b1;
                        left_open_flag = 1'b1;
                        open_on = 1'b1;
                        open_ms = '0;
                        r.left_open_change = 1'b1;
                    end
                    step_blinker();
                end else begin
                    toggles_left = '0;
                    blink_endless = 1'b0;
                    if (left_open_flag) begin
                        left_open_flag = 1'b0;
                        r.left_open_change = 1'b1;
                    end
                    open_on = 1'b0;
                    open_ms = '0;
                    door = dlac_pkg::MODE_CLOSED;
                end
            end
        endcase
        r.door_mode = door;
        r.locked_led = locked_lamp;
        r.open_led = open_lamp;
        r.left_open = left_open_flag;
        return r;
    endfunction

    function automatic dlac_pkg::t_in_word make_poll(logic tick, logic key_v, logic [3:0] key,
                                                     logic tag_v, logic [63:0] tag, logic save,
                                                     logic button, logic magnet);
        dlac_pkg::t_in_word w;
        w.ms_tick = tick;
        w.key_valid = key_v;
        w.key_value = key;
        w.tag_valid = tag_v;
        w.tag_id = tag;
        w.save_request = save;
        w.lock_button = button;
        w.magnet_closed = magnet;
        return w;
    endfunction

    // Mostly well-formed traffic for the current door mode, with noise on top.
    function automatic dlac_pkg::t_in_word random_poll();
        dlac_pkg::t_in_word w;
        int                 pick;
        int                 slot;
        w.ms_tick = $urandom_range(0, 99) < tick_pct;
        w.key_valid = $urandom_range(0, 9) == 0;
        w.key_value = 4'($urandom);
        w.tag_valid = $urandom_range(0, 9) == 0;
        w.tag_id = {$urandom, $urandom};
        w.save_request = $urandom_range(0, 9) == 0;
        w.lock_button = $urandom_range(0, 9) == 0;
        w.magnet_closed = 1'($urandom);
        pick = $urandom_range(0, 99);
        case (door)
            dlac_pkg::MODE_CLOSED: begin
                if (pick < 55) begin
                    slot = 3 - key_count;
                    w.key_valid = 1'b1;
                    w.key_value = cfg_code[slot * 4 +: 4];
                end else if (pick < 70) begin
                    w.tag_valid = 1'b1;
                    w.tag_id = known_tags[$urandom_range(0, 3)];
                    w.save_request = $urandom_range(0, 4) == 0;
                end else if (pick < 85) begin
                    w.key_valid = 1'b1;
                end
            end
            dlac_pkg::MODE_OPEN: w.lock_button = pick < 15;
            dlac_pkg::MODE_CLOSING: w.magnet_closed = pick < 60;
            default: w.lock_button = pick < 30;
        endcase
        return w;
    endfunction

    function automatic string word_text(dlac_pkg::t_out_word x);
        return $sformatf("mode=%0d locked=%b open=%b wrong=%b access=%b saved=%b chg=%b left=%b",
                         x.door_mode, x.locked_led, x.open_led, x.wrong_event,
                         x.access_event, x.saved_event, x.left_open_change, x.left_open);
    endfunction

    function automatic void check_result(dlac_pkg::t_out_word got);
        dlac_pkg::t_out_word want;
        if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("unexpected result word: %s", word_text(got));
            end
            return;
        end
        want = expected_words.pop_front();
        if (got.door_mode !== want.door_mode || got.locked_led !== want.locked_led ||
            got.open_led !== want.open_led || got.wrong_event !== want.wrong_event ||
            got.access_event !== want.access_event || got.saved_event !== want.saved_event ||
            got.left_open_change !== want.left_open_change ||
            got.left_open !== want.left_open) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d mismatch: expected %s", results_checked, word_text(want));
                $display("result %0d mismatch: actual   %s", results_checked, word_text(got));
            end
        end
        results_checked++;
    endfunction

    task automatic offer_poll(dlac_pkg::t_in_word w, bit typed,
                              dlac_pkg::t_out_word typed_want);
        dlac_pkg::t_out_word want;
        int                  gap;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        want = poll_lock(w);
        if (typed) begin
            want = typed_want;
        end
        expected_words.push_back(want);
        polls_sent++;
        openings += want.access_event;
        wrong_reports += want.wrong_event;
        left_open_changes += want.left_open_change;
        tags_stored += want.saved_event;
        gap = in_rush ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [2:0] index, logic [19:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (index)
            dlac_pkg::CFG_ACCESS_CODE:  cfg_code = data[15:0];
            dlac_pkg::CFG_ENTRY_TMO:    cfg_entry_limit = data;
            dlac_pkg::CFG_OPEN_TMO:     cfg_open_limit = data;
            dlac_pkg::CFG_BLINK_IVL:    cfg_blink_period = data;
            dlac_pkg::CFG_WRONG_BLINKS: cfg_blink_count = data[7:0];
            default: ;
        endcase
    endtask

    // Output side: random stall after each word, plus long hold-offs on request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_result(o_out_word);
                stall_left = out_rush ? 0 : $urandom_range(0, 14);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            if (hold_asked != hold_done) begin
                stall_left = LONG_HOLD;
                hold_done++;
            end
            i_out_stall <= stall_left != 0;
        end
    end

    initial begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_directed_row rows[$];
        logic [63:0]   ones;
        logic [15:0]   code;
        logic [19:0]   entry_limit;
        logic [19:0]   open_limit;
        logic [19:0]   blink_period;
        logic [7:0]    blink_count;

        ones = '1;
        known_tags[0] = '0;
        known_tags[1] = ones;
        known_tags[2] = {$urandom, $urandom};
        known_tags[3] = {$urandom, $urandom};
        reset_lock_model();

        // Reset settings: code 1-2-3-4, long timeouts, six toggles.
        rows.push_back('{make_poll(0, 0, 0, 0, 0, 0, 0, 1), 1,
                         '{dlac_pkg::MODE_CLOSED, 1, 0, 0, 0, 0, 0, 0}});
        rows.push_back('{make_poll(0, 0, 0, 1, ones, 0, 0, 1), 1,
                         '{dlac_pkg::MODE_CLOSED, 1, 0, 1, 0, 0, 0, 0}});
        rows.push_back('{make_poll(0, 0, 0, 0, 0, 1, 0, 1), 1,
                         '{dlac_pkg::MODE_CLOSED, 1, 0, 0, 0, 0, 0, 0}});
        rows.push_back('{make_poll(0, 0, 0, 1, ones, 1, 0, 1), 1,
                         '{dlac_pkg::MODE_OPENING, 1, 0, 0, 0, 1, 0, 0}});
        rows.push_back('{make_poll(0, 0, 0, 0, 0, 0, 0, 1), 1,
                         '{dlac_pkg::MODE_OPEN, 1, 0, 0, 1, 0, 0, 0}});
        rows.push_back('{make_poll(0, 0, 0, 0, 0, 0, 1, 1), 1,
                         '{dlac_pkg::MODE_CLOSING, 0, 1, 0, 0, 0, 0, 0}});
        rows.push_back('{make_poll(0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{dlac_pkg::MODE_CLOSING, 0, 1, 0, 0, 0, 1, 1}});
        rows.push_back('{make_poll(0, 0, 0, 0, 0, 0, 0, 1), 1,
                         '{dlac_pkg::MODE_CLOSED, 0, 1, 0, 0, 0, 1, 0}});
        rows.push_back('{make_poll(1, 1, 1, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(0, 1, 2, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(1, 1, 3, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(0, 1, 4, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(1, 0, 0, 0, 0, 0, 1, 1), 0, '0});
        rows.push_back('{make_poll(0, 0, 0, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(0, 1, 1, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(0, 1, 2, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(0, 1, 3, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(1, 1, 4, 1, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(0, 1, 15, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(1, 1, 0, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(0, 1, 15, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(1, 1, 0, 1, ones, 0, 0, 1), 0, '0});
        rows.push_back('{make_poll(1, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_poll(0, 0, 0, 0, 0, 0, 1, 0), 0, '0});
        rows.push_back('{make_poll(1, 0, 0, 0, 0, 0, 0, 1), 0, '0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            offer_poll(rows[i].poll, rows[i].typed, rows[i].want);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            pause_until_drained();
            case (phase)
                0: begin
                    code = 16'($urandom); entry_limit = 30; open_limit = 8;
                    blink_period = 2; blink_count = 4;
                end
                1: begin
                    code = '0; entry_limit = '0; open_limit = '0;
                    blink_period = '0; blink_count = '0;
                end
                2: begin
                    code = '1; entry_limit = '1; open_limit = '1;
                    blink_period = '1; blink_count = '1;
                end
                3: begin
                    code = 16'($urandom); entry_limit = 1; open_limit = 1;
                    blink_period = 1; blink_count = '1;
                end
                default: begin
                    code = 16'($urandom);
                    entry_limit = 20'($urandom_range(0, 40));
                    open_limit = 20'($urandom_range(0, 20));
                    blink_period = 20'($urandom_range(0, 6));
                    blink_count = 8'($urandom_range(0, 12));
                end
            endcase
            write_reg(dlac_pkg::CFG_ACCESS_CODE, {4'($urandom), code});
            write_reg(dlac_pkg::CFG_ENTRY_TMO, entry_limit);
            write_reg(dlac_pkg::CFG_OPEN_TMO, open_limit);
            write_reg(dlac_pkg::CFG_BLINK_IVL, blink_period);
            write_reg(dlac_pkg::CFG_WRONG_BLINKS, {12'($urandom), blink_count});
            write_reg(dlac_pkg::CFG_WRONG_BLINKS + 3'($urandom_range(1, 3)),
                      20'($urandom));
            i_cfg_valid <= 1'b0;

            tick_pct = (phase == 1) ? 30 : 50;
            in_rush = phase % 3 == 1;
            out_rush <= phase % 4 == 2;
            if (phase == 0) begin
                hold_asked <= hold_asked + 1;
                in_rush = 1'b1;
            end
            for (int n = 0; n < PHASE_POLLS; n++) begin
                if (phase == 0 && n == 30) begin
                    in_rush = 1'b0;
                end
                if (phase == 3 && n == PHASE_POLLS / 2) begin
                    pause_until_drained();
                end
                offer_poll(random_poll(), 0, '0);
            end
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d polls over %0d register settings, %0d results checked",
                 polls_sent, PHASE_COUNT + 1, results_checked);
        $display("tb: %0d openings, %0d wrong reports, %0d left-open changes, %0d tags stored",
                 openings, wrong_reports, left_open_changes, tags_stored);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
